// ===== sv/lzrt_pkg.sv =====
// lzrt_pkg: types, constants and the node merge for the longest zero run range tree
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
package lzrt_pkg;

  localparam int NUM_POSITIONS = 1024;
  localparam int IDX_W  = $clog2(NUM_POSITIONS);          // position index
  localparam int CNT_W  = $clog2(NUM_POSITIONS) + 1;      // run lengths
  localparam int NODE_W = $clog2(2 * NUM_POSITIONS);      // tree node address
  localparam int PTR_W  = NODE_W + 1;                     // range bounds, may reach 2*N
  localparam int TREE_NODES = 2 * NUM_POSITIONS;

  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [9:0]         start_index;
    logic [10:0]        end_index;
    logic signed [31:0] update_value;
  } in_item_t;

  typedef struct packed {
    logic [10:0] longest_zeros;
    logic        range_empty;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] pre;
    logic [CNT_W-1:0] suf;
    logic [CNT_W-1:0] best;
    logic             all;
  } node_t;

  localparam node_t NODE_EMPTY = '{pre: '0, suf: '0, best: '0, all: 1'b1};
  localparam node_t NODE_ONE   = '{pre: CNT_W'(1), suf: CNT_W'(1), best: CNT_W'(1), all: 1'b1};
  localparam node_t NODE_NONE  = '{pre: '0, suf: '0, best: '0, all: 1'b0};

  typedef enum logic [1:0] {
    RD_LO    = 2'd0,
    RD_HI    = 2'd1,
    RD_LEFT  = 2'd2,
    RD_RIGHT = 2'd3
  } rd_src_t;

  typedef struct packed {
    logic    load;       // capture an accepted item
    logic    wr_leaf;    // write the leaf of an accepted update
    logic    rd_en;
    rd_src_t rd_src;
    logic    cap_a;      // hold the left child
    logic    wr_merge;   // write the recombined node, step up
    logic    mrg_left;
    logic    inc_lo;
    logic    dec_hi;
    logic    mrg_right;
    logic    shift;
    logic    clr_wr;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic lo_lt_hi;
    logic lo_odd;
    logic hi_odd;
    logic p_root;
    logic clr_last;
    logic in_empty;
  } stat_t;

  function automatic node_t merge(input node_t a, input node_t b);
    node_t            z;
    logic [CNT_W-1:0] mid;
    mid    = a.suf + b.pre;
    z.pre  = a.all ? a.pre + b.pre : a.pre;
    z.suf  = b.all ? b.suf + a.suf : b.suf;
    z.best = (a.best > b.best) ? a.best : b.best;
    if (mid > z.best) begin
      z.best = mid;
    end
    z.all  = a.all & b.all;
    return z;
  endfunction

endpackage

// ===== sv/lzrt_ctrl.sv =====
// lzrt_ctrl: sequencer for clearing, updates and range queries
// depends on lzrt_pkg; drives lzrt_dpath through command and status structs
`timescale 1ns / 1ps
module lzrt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           kind,
  input  lzrt_pkg::stat_t stat,
  output lzrt_pkg::cmd_t  cmd,
  output logic           busy
);
  import lzrt_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_UPL   = 11'b000_0000_0100,
    S_UPR   = 11'b000_0000_1000,
    S_UPM   = 11'b000_0001_0000,
    S_QLO   = 11'b000_0010_0000,
    S_QLOM  = 11'b000_0100_0000,
    S_QHI   = 11'b000_1000_0000,
    S_QHIM  = 11'b001_0000_0000,
    S_QSH   = 11'b010_0000_0000,
    S_QFIN  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_src = RD_LO;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (kind == KIND_UPDATE) begin
            cmd.wr_leaf = 1'b1;
            state_nxt   = S_UPL;
          end else if (stat.in_empty) begin
            state_nxt = S_QFIN;
          end else begin
            state_nxt = S_QLO;
          end
        end
      end
      S_UPL: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_LEFT;
        state_nxt  = S_UPR;
      end
      S_UPR: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_RIGHT;
        cmd.cap_a  = 1'b1;
        state_nxt  = S_UPM;
      end
      S_UPM: begin
        cmd.wr_merge = 1'b1;
        state_nxt    = stat.p_root ? S_IDLE : S_UPL;
      end
      S_QLO: begin
        if (!stat.lo_lt_hi) begin
          state_nxt = S_QFIN;
        end else if (stat.lo_odd) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_LO;
          state_nxt  = S_QLOM;
        end else begin
          state_nxt = S_QHI;
        end
      end
      S_QLOM: begin
        cmd.mrg_left = 1'b1;
        cmd.inc_lo   = 1'b1;
        state_nxt    = S_QHI;
      end
      S_QHI: begin
        if (stat.hi_odd) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_HI;
          cmd.dec_hi = 1'b1;
          state_nxt  = S_QHIM;
        end else begin
          state_nxt = S_QSH;
        end
      end
      S_QHIM: begin
        cmd.mrg_right = 1'b1;
        state_nxt     = S_QSH;
      end
      S_QSH: begin
        cmd.shift = 1'b1;
        state_nxt = S_QLO;
      end
      S_QFIN: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== sv/lzrt_dpath.sv =====
// lzrt_dpath: node memory, range bounds, accumulators and result register
// depends on lzrt_pkg; commanded by lzrt_ctrl
`timescale 1ns / 1ps
module lzrt_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  lzrt_pkg::in_item_t  in_data,
  input  lzrt_pkg::cmd_t      cmd,
  output lzrt_pkg::stat_t     stat,
  output logic               out_valid,
  output lzrt_pkg::out_item_t out_data
);
  import lzrt_pkg::*;

  node_t mem [TREE_NODES];
  node_t rd_q;

  logic [PTR_W-1:0]  lo_r, hi_r, lo_nxt, hi_nxt;
  logic [NODE_W-1:0] p_r, p_nxt;
  logic [NODE_W-1:0] clr_r;
  logic [CNT_W-1:0]  len_r;
  node_t             left_r, right_r, a_r, left_nxt, right_nxt, total;
  logic              empty_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [CNT_W-1:0]  end_c;
  logic              wen;
  logic [NODE_W-1:0] waddr, raddr;
  node_t             wdata, leaf;
  logic [PTR_W-1:0]  hi_m1;

  // clamp the query end to the array
  assign end_c = (in_data.end_index > CNT_W'(NUM_POSITIONS)) ? CNT_W'(NUM_POSITIONS)
                                                             : in_data.end_index;
  assign leaf  = (in_data.update_value == '0) ? NODE_ONE : NODE_NONE;
  assign hi_m1 = hi_r - PTR_W'(1);

  assign stat.lo_lt_hi = (lo_r < hi_r);
  assign stat.lo_odd   = lo_r[0];
  assign stat.hi_odd   = hi_r[0];
  assign stat.p_root   = (p_r == NODE_W'(1));
  assign stat.clr_last = (clr_r == NODE_W'(TREE_NODES - 1));
  assign stat.in_empty = ({1'b0, in_data.start_index} >= end_c);

  always_comb begin
    wen   = 1'b0;
    waddr = clr_r;
    wdata = NODE_NONE;
    if (cmd.clr_wr) begin
      wen = 1'b1;
      if (clr_r != '0) begin
        wdata = '{pre: len_r, suf: len_r, best: len_r, all: 1'b1};
      end
    end else if (cmd.wr_leaf) begin
      wen   = 1'b1;
      waddr = NODE_W'({1'b0, in_data.start_index} + CNT_W'(NUM_POSITIONS));
      wdata = leaf;
    end else if (cmd.wr_merge) begin
      wen   = 1'b1;
      waddr = p_r;
      wdata = merge(a_r, rd_q);
    end
  end

  always_comb begin
    case (cmd.rd_src)
      RD_LO:    raddr = lo_r[NODE_W-1:0];
      RD_HI:    raddr = hi_m1[NODE_W-1:0];
      RD_LEFT:  raddr = {p_r[NODE_W-2:0], 1'b0};
      RD_RIGHT: raddr = {p_r[NODE_W-2:0], 1'b1};
      default:  raddr = lo_r[NODE_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q <= mem[raddr];
    end
  end

  // clear pass: node length halves at every power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      len_r <= CNT_W'(NUM_POSITIONS);
    end else if (cmd.clr_wr) begin
      clr_r <= clr_r + NODE_W'(1);
      if (clr_r != '0 && ((clr_r + NODE_W'(1)) & clr_r) == '0) begin
        len_r <= len_r >> 1;
      end
    end
  end

  always_comb begin
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    p_nxt     = p_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    if (cmd.load) begin
      lo_nxt    = PTR_W'(in_data.start_index) + PTR_W'(NUM_POSITIONS);
      hi_nxt    = PTR_W'(end_c) + PTR_W'(NUM_POSITIONS);
      p_nxt     = NODE_W'((PTR_W'(in_data.start_index) + PTR_W'(NUM_POSITIONS)) >> 1);
      left_nxt  = NODE_EMPTY;
      right_nxt = NODE_EMPTY;
    end
    if (cmd.wr_merge) begin
      p_nxt = p_r >> 1;
    end
    if (cmd.mrg_left) begin
      left_nxt = merge(left_r, rd_q);
    end
    if (cmd.inc_lo) begin
      lo_nxt = lo_r + PTR_W'(1);
    end
    if (cmd.dec_hi) begin
      hi_nxt = hi_m1;
    end
    if (cmd.mrg_right) begin
      right_nxt = merge(rd_q, right_r);
    end
    if (cmd.shift) begin
      lo_nxt = lo_r >> 1;
      hi_nxt = hi_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    p_r     <= p_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    if (cmd.cap_a) begin
      a_r <= rd_q;
    end
    if (cmd.load) begin
      empty_r <= stat.in_empty;
    end
  end

  assign total = merge(left_r, right_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.longest_zeros <= empty_r ? '0 : total.best;
      out_r.range_empty   <= empty_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== sv/longest_zero_run_range_tree.sv =====
// longest zero run over a range tree of 1024 positions, one node memory port.
// update: writes the leaf, then reads both children and writes their merge at each
// level up to the root; no result. query: at most 11 levels, merging the node at
// each odd bound; the result strobe is registered and cannot be held off;
// one item at a time. after reset the memory is swept once with busy high.
`timescale 1ns / 1ps
module longest_zero_run_range_tree (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lzrt_pkg::in_item_t  in_data,
  output logic               out_valid,
  output lzrt_pkg::out_item_t out_data
);
  import lzrt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lzrt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_data.kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lzrt_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== sv/lzrt_checker.sv =====
// lzrt_checker: port-level checks for the longest zero run range tree
// depends on lzrt_pkg; bound to longest_zero_run_range_tree
`timescale 1ns / 1ps
module lzrt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input lzrt_pkg::out_item_t out_data,
  input logic               out_valid
);
  import lzrt_pkg::*;

  // sweep after reset keeps the block busy
  a_clear_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.range_empty) |-> (out_data.longest_zeros == '0))
    else $error("empty range with nonzero run");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.longest_zeros <= 11'(NUM_POSITIONS)))
    else $error("run longer than the array");

endmodule

bind longest_zero_run_range_tree lzrt_checker u_lzrt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_data  (out_data),
  .out_valid (out_valid)
);

// ===== dv/longest_zero_run_range_tree_tb.sv =====
// testbench for longest_zero_run_range_tree: directed table then random updates and queries
// depends on lzrt_pkg and the block; predicts results with a plain array model
`timescale 1ns / 1ps
module longest_zero_run_range_tree_tb;
  import lzrt_pkg::*;

  localparam int RANDOM_ITEMS = 1330;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;

  longest_zero_run_range_tree dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // zero map of the array: 1 where the position holds zero
  bit zero_map [NUM_POSITIONS];
  out_item_t pending_runs[$];
  int errors = 0;
  longint cycles = 0;
  int idle_pct = 7;

  function automatic out_item_t run_of_zeros(input in_item_t it);
    out_item_t r;
    int e, cur, best;
    r = '0;
    e = (it.end_index > NUM_POSITIONS) ? NUM_POSITIONS : it.end_index;
    if (it.start_index >= e) begin
      r.range_empty = 1'b1;
      return r;
    end
    cur = 0;
    best = 0;
    for (int i = it.start_index; i < e; i++) begin
      cur = zero_map[i] ? cur + 1 : 0;
      if (cur > best) best = cur;
    end
    r.longest_zeros = best[10:0];
    return r;
  endfunction

  // checking of results at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (pending_runs.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        out_item_t want;
        want = pending_runs.pop_front();
        if (want.longest_zeros !== out_data.longest_zeros ||
            want.range_empty !== out_data.range_empty) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // offers one item, holds start until accepted, predicts on acceptance
  // start is left high at the closing falling edge; the next item keeps it high, an idle cycle drops it
  task automatic send_item(input in_item_t it, input bit has_want, input out_item_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (it.kind == KIND_UPDATE) begin
      if (it.start_index < NUM_POSITIONS) zero_map[it.start_index] = (it.update_value == 0);
    end else begin
      out_item_t p;
      p = run_of_zeros(it);
      if (has_want && p !== want) begin
        $display("%0t: directed row expected %p predicted %p", $time, want, p);
        errors++;
      end
      pending_runs.push_back(p);
    end
    @(negedge clk);
  endtask

  function automatic in_item_t make_item(input logic k, input int s, input int e, input int v);
    in_item_t it;
    it.kind = k;
    it.start_index = s[9:0];
    it.end_index = e[10:0];
    it.update_value = v;
    return it;
  endfunction

  typedef struct {
    in_item_t item;
    bit has_want;
    out_item_t want;
  } stim_row_t;

  stim_row_t directed_rows[$];

  function automatic void add_row(input logic k, input int s, input int e, input int v,
                                  input bit hw, input int lz, input bit em);
    stim_row_t r;
    r.item = make_item(k, s, e, v);
    r.has_want = hw;
    r.want.longest_zeros = lz[10:0];
    r.want.range_empty = em;
    directed_rows.push_back(r);
  endfunction

  in_item_t it;
  out_item_t none;

  initial begin
    none = '0;
    foreach (zero_map[i]) zero_map[i] = 1'b1;
    // after reset: all zero array
    add_row(KIND_QUERY, 0, 1024, 0, 1, 1024, 0);
    add_row(KIND_QUERY, 0, 2047, 0, 1, 1024, 0);   // end clamped
    add_row(KIND_QUERY, 5, 5, 0, 1, 0, 1);         // empty range
    add_row(KIND_QUERY, 1023, 1024, 0, 1, 1, 0);
    add_row(KIND_QUERY, 1023, 0, 0, 1, 0, 1);
    add_row(KIND_QUERY, 1023, 2047, 0, 1, 1, 0);
    add_row(KIND_UPDATE, 0, 2047, 32'h8000_0000, 0, 0, 0);
    add_row(KIND_UPDATE, 1023, 0, 32'h7fff_ffff, 0, 0, 0);
    add_row(KIND_UPDATE, 512, 1024, -1, 0, 0, 0);
    add_row(KIND_QUERY, 0, 1024, 0, 1, 511, 0);
    add_row(KIND_QUERY, 0, 1, 0, 1, 0, 0);
    add_row(KIND_QUERY, 1, 512, 0, 0, 0, 0);
    add_row(KIND_QUERY, 511, 514, 0, 0, 0, 0);
    add_row(KIND_UPDATE, 512, 0, 0, 0, 0, 0);       // back to zero
    add_row(KIND_QUERY, 0, 1024, 0, 0, 0, 0);
    add_row(KIND_UPDATE, 341, 0, 32'h5555_5555, 0, 0, 0);
    add_row(KIND_UPDATE, 682, 0, 32'haaaa_aaaa, 0, 0, 0);
    add_row(KIND_QUERY, 300, 700, 0, 0, 0, 0);
    add_row(KIND_QUERY, 682, 683, 0, 1, 0, 0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].has_want, directed_rows[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      int s, e, sel;
      if (n == RANDOM_ITEMS / 3) idle_pct = 66;
      if (n == 2 * RANDOM_ITEMS / 3) idle_pct = 0;
      // once, hold off until every outstanding result has come
      if (n == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        @(negedge clk);
        while (pending_runs.size() != 0) @(negedge clk);
      end
      sel = $urandom_range(99);
      if (sel < 50) begin
        // dense ones keep runs short and varied
        it = make_item(KIND_UPDATE, $urandom_range(1023), $urandom_range(2047),
                       ($urandom_range(2) == 0) ? 0 : $urandom);
      end else begin
        s = $urandom_range(1023);
        if (sel < 80) e = s + 1 + $urandom_range(1023 - s);
        else if (sel < 90) e = s + 1 + $urandom_range(7);
        else e = $urandom_range(2047);
        it = make_item(KIND_QUERY, s, e, $urandom);
      end
      send_item(it, 0, none);
    end

    start <= 1'b0;
    while (pending_runs.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
